[src/lcd_pkg.sv]
// Shared constants, codes, types and arithmetic helpers of the lasso
// coordinate descent block. Every other file of the block but lcd_ram imports this package.
package lcd_pkg;

   // Storage geometry and number format.
   localparam int MAX_ROWS  = 256;
   localparam int MAX_COLS  = 32;
   localparam int FRAC_BITS = 16;

   localparam int DATA_W  = 32;
   localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int NROW_W  = $clog2(MAX_ROWS + 1);
   localparam int NCOL_W  = $clog2(MAX_COLS + 1);
   localparam int XADDR_W = ROW_W + COL_W;

   // Exact sums of Q32.32 products over all rows need this much headroom.
   localparam int ACC_W  = 2 * DATA_W + ROW_W + 2;
   localparam int PROD_W = 2 * DATA_W + 1;
   localparam int DIV_W  = ACC_W - FRAC_BITS;
   localparam int DVS_W  = NROW_W + 1;
   localparam int OBJ_W  = 64;

   // Port field widths.
   localparam int CMD_W       = 3;
   localparam int ROW_FIELD_W = 8;
   localparam int COL_FIELD_W = 5;
   localparam int SWEEP_W     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 31;
   localparam int N_REG_W     = 9;
   localparam int P_REG_W     = 6;
   localparam int PEN_W       = 31;

   // Register reset values.
   localparam int TOL_RESET   = 66;
   localparam int LIMIT_RESET = 1000;

   typedef enum logic [CMD_W-1:0] {
      OP_LOAD_X = 3'd0,
      OP_LOAD_Y = 3'd1,
      OP_LOAD_B = 3'd2,
      OP_ZERO_B = 3'd3,
      OP_RUN    = 3'd4
   } lcd_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS  = 3'd0,
      CSR_COLS  = 3'd1,
      CSR_PEN   = 3'd2,
      CSR_TOL   = 3'd3,
      CSR_LIMIT = 3'd4
   } lcd_csr_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_CLR,
      ACC_LOAD_Y,
      ACC_ADD,
      ACC_SUB
   } lcd_acc_op_type;

   typedef enum logic [2:0] {
      MUL_X_COEF,
      MUL_R_R,
      MUL_PEN,
      MUL_X_BJ,
      MUL_X_T,
      MUL_X_DELTA
   } lcd_mul_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ROW_RD,
      ST_ROW_LD,
      ST_ELEM_RD,
      ST_ELEM_MUL,
      ST_ELEM_ACC,
      ST_ROW_RES,
      ST_ROW_SQ,
      ST_ROW_ACC,
      ST_PEN_MUL,
      ST_PEN_ACC,
      ST_OBJ_DIV,
      ST_OBJ_WAIT,
      ST_OBJ_SUM,
      ST_OBJ_CMP,
      ST_COL_START,
      ST_CR_RD,
      ST_CR_MUL1,
      ST_CR_T,
      ST_CR_MUL2,
      ST_CR_ACC,
      ST_RHO_DIV,
      ST_RHO_WAIT,
      ST_RHO_SAT,
      ST_SOFT,
      ST_UPD_CHK,
      ST_UR_RD,
      ST_UR_MUL,
      ST_UR_WR,
      ST_EMIT
   } lcd_state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic                      ld_x;
      logic                      ld_y;
      logic                      ld_b;
      logic                      zero_b;
      logic                      mem_rd;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          col;
      lcd_acc_op_type            acc_op;
      logic                      loss_clr;
      logic                      loss_add;
      logic                      mul_en;
      lcd_mul_sel_type           mul_sel;
      logic                      res_save;
      logic                      res_wr_fresh;
      logic                      res_wr_upd;
      logic                      t_save;
      logic                      bj_load;
      logic                      pen_save;
      logic                      div_start_loss;
      logic                      div_start_rho;
      logic                      rho_save;
      logic                      bn_save;
      logic                      coef_update;
      logic                      f_save;
      logic                      fold_save;
      logic                      out_load;
      logic                      out_last;
      logic [SWEEP_W-1:0]        sweeps;
   } lcd_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic div_busy;
      logic changed;
      logic converged;
      logic out_stall;
   } lcd_status_type;

   // Divide by 2^FRAC_BITS, truncating toward zero.
   function automatic logic signed [ACC_W-1:0] shift_trunc(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-1:0] mag;
      mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      mag = mag >> FRAC_BITS;
      return v[ACC_W-1] ? -$signed(mag) : $signed(mag);
   endfunction

   // Saturate to a signed 32-bit value.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (!v[ACC_W-1] && (|v[ACC_W-2:DATA_W-1])) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v[ACC_W-1] && !(&v[ACC_W-2:DATA_W-1])) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

[src/lcd_req_if.sv]
// Request channel of the lasso coordinate descent block: valid, ready and
// one command item. Depends on lcd_pkg.
interface lcd_req_if;
   import lcd_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [CMD_W-1:0]              cmd;
   logic [ROW_FIELD_W-1:0]        row;
   logic [COL_FIELD_W-1:0]        col;
   logic signed [DATA_W-1:0]      value;

   modport source (output valid, cmd, row, col, value, input ready);
   modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

[src/lcd_rsp_if.sv]
// Result channel of the lasso coordinate descent block: valid, ready and
// one fitted coefficient. Depends on lcd_pkg.
interface lcd_rsp_if;
   import lcd_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [COL_FIELD_W-1:0]        coef_index;
   logic signed [DATA_W-1:0]      coef_value;
   logic [SWEEP_W-1:0]            sweeps_done;
   logic                          last;

   modport source (output valid, coef_index, coef_value, sweeps_done, last, input ready);
   modport sink   (input valid, coef_index, coef_value, sweeps_done, last, output ready);
endinterface

[src/lcd_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the matrix, response and residual stores.
module lcd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[src/lcd_div.sv]
// Restoring divider, one quotient bit per cycle, for the scaled sums.
// Depends on lcd_pkg for its widths.
module lcd_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lcd_pkg::DIV_W-1:0]  dividend,
   input  logic [lcd_pkg::DVS_W-1:0]  divisor,
   output logic                       busy,
   output logic [lcd_pkg::DIV_W-1:0]  quotient
);
   import lcd_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [DVS_W:0]   rem_ff;
   logic [DVS_W:0]   rem_sh;
   logic [DIV_W-1:0] quo_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic             fits;

   // Trial subtraction of the divisor from the shifted remainder.
   always_comb begin
      rem_sh = {rem_ff[DVS_W-1:0], quo_ff[DIV_W-1]};
      fits   = rem_sh >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;
endmodule

[src/lcd_datapath.sv]
// Datapath of the lasso coordinate descent block: stores, coefficient file,
// multiplier, accumulators, divider and result register. Depends on lcd_pkg,
// lcd_ram and lcd_div.
module lcd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  lcd_pkg::lcd_cmd_type              cmd,
   input  logic [lcd_pkg::ROW_FIELD_W-1:0]   req_row,
   input  logic [lcd_pkg::COL_FIELD_W-1:0]   req_col,
   input  logic signed [lcd_pkg::DATA_W-1:0] req_value,
   input  logic [lcd_pkg::PEN_W-1:0]         penalty,
   input  logic [lcd_pkg::PEN_W-1:0]         tolerance,
   input  logic [lcd_pkg::NROW_W-1:0]        rows_eff,
   output lcd_pkg::lcd_status_type           status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lcd_pkg::COL_FIELD_W-1:0]   rsp_coef_index,
   output logic signed [lcd_pkg::DATA_W-1:0] rsp_coef_value,
   output logic [lcd_pkg::SWEEP_W-1:0]       rsp_sweeps_done,
   output logic                              rsp_last
);
   import lcd_pkg::*;

   logic signed [DATA_W-1:0] x_rd, y_rd, r_rd;
   logic signed [DATA_W-1:0] coef_ff [MAX_COLS];
   logic signed [DATA_W-1:0] coef_rd;
   logic signed [DATA_W-1:0] mul_a;
   logic signed [DATA_W:0]   mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  prod_ext, mq;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]         loss_ff, abs_acc;
   logic signed [DATA_W-1:0] res_ff, t_ff, bj_ff, rho_ff, bn_ff, bn_in, res_upd;
   logic signed [DATA_W:0]   delta_ff;
   logic [OBJ_W-1:0]         pen_ff, f_ff, fold_ff;
   logic                     rho_neg_ff;
   logic [DIV_W-1:0]         div_dividend, div_q;
   logic [DVS_W-1:0]         div_divisor;
   logic                     div_busy;
   logic signed [ACC_W-1:0]  q_ext;
   logic [DATA_W:0]          rho_mag;
   logic signed [DATA_W+1:0] soft_d;
   logic                     rsp_valid_ff;
   logic [COL_FIELD_W-1:0]   out_idx_ff;
   logic signed [DATA_W-1:0] out_val_ff;
   logic [SWEEP_W-1:0]       out_sweeps_ff;
   logic                     out_last_ff;

   // Matrix, response and residual stores.
   lcd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_x_ram (
      .clock (clock),
      .we    (cmd.ld_x),
      .waddr ({ROW_W'(req_row), COL_W'(req_col)}),
      .wdata (req_value),
      .re    (cmd.mem_rd),
      .raddr ({cmd.row, cmd.col}),
      .rdata (x_rd)
   );

   lcd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_y_ram (
      .clock (clock),
      .we    (cmd.ld_y),
      .waddr (ROW_W'(req_row)),
      .wdata (req_value),
      .re    (cmd.mem_rd),
      .raddr (cmd.row),
      .rdata (y_rd)
   );

   lcd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_r_ram (
      .clock (clock),
      .we    (cmd.res_wr_fresh | cmd.res_wr_upd),
      .waddr (cmd.row),
      .wdata (cmd.res_wr_fresh ? res_ff : res_upd),
      .re    (cmd.mem_rd),
      .raddr (cmd.row),
      .rdata (r_rd)
   );

   // Coefficient file.
   assign coef_rd = coef_ff[cmd.col];

   always_ff @(posedge clock) begin
      if (reset || cmd.zero_b) begin
         for (int k = 0; k < MAX_COLS; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (cmd.ld_b) begin
         coef_ff[COL_W'(req_col)] <= req_value;
      end else if (cmd.coef_update) begin
         coef_ff[cmd.col] <= bn_ff;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_X_COEF: begin
            mul_a = x_rd;
            mul_b = (DATA_W+1)'(coef_rd);
         end
         MUL_R_R: begin
            mul_a = res_ff;
            mul_b = (DATA_W+1)'(res_ff);
         end
         MUL_PEN: begin
            mul_a = $signed({1'b0, penalty});
            mul_b = coef_rd[DATA_W-1] ? -(DATA_W+1)'(coef_rd) : (DATA_W+1)'(coef_rd);
         end
         MUL_X_BJ: begin
            mul_a = x_rd;
            mul_b = (DATA_W+1)'(bj_ff);
         end
         MUL_X_T: begin
            mul_a = x_rd;
            mul_b = (DATA_W+1)'(t_ff);
         end
         MUL_X_DELTA: begin
            mul_a = x_rd;
            mul_b = delta_ff;
         end
         default: begin
            mul_a = x_rd;
            mul_b = delta_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   assign prod_ext = ACC_W'(prod_ff);
   assign mq       = shift_trunc(prod_ext);
   assign res_upd  = sat32(ACC_W'(r_rd) - mq);

   // Main accumulator.
   always_comb begin
      unique case (cmd.acc_op)
         ACC_HOLD:   acc_in = acc_ff;
         ACC_CLR:    acc_in = '0;
         ACC_LOAD_Y: acc_in = ACC_W'(y_rd) <<< FRAC_BITS;
         ACC_ADD:    acc_in = acc_ff + prod_ext;
         ACC_SUB:    acc_in = acc_ff - prod_ext;
         default:    acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign abs_acc = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   // Loss accumulator, residual, partial residual, old coefficient and penalty registers.
   always_ff @(posedge clock) begin
      if (cmd.loss_clr) begin
         loss_ff <= '0;
      end else if (cmd.loss_add) begin
         loss_ff <= loss_ff + ACC_W'(prod_ext);
      end
      if (cmd.res_save) begin
         res_ff <= sat32(shift_trunc(acc_ff));
      end
      if (cmd.t_save) begin
         t_ff <= sat32(ACC_W'(r_rd) + mq);
      end
      if (cmd.bj_load) begin
         bj_ff <= coef_rd;
      end
      if (cmd.pen_save) begin
         pen_ff <= OBJ_W'(acc_ff >>> FRAC_BITS);
      end
   end

   // Divider for the loss over 2n and for rho over n.
   assign div_dividend = cmd.div_start_loss ? DIV_W'(loss_ff >> FRAC_BITS)
                                            : DIV_W'(abs_acc >> FRAC_BITS);
   assign div_divisor  = cmd.div_start_loss ? {rows_eff, 1'b0} : {1'b0, rows_eff};

   lcd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start_loss | cmd.div_start_rho),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // Soft threshold of rho by the penalty.
   assign q_ext   = ACC_W'(div_q);
   assign rho_mag = rho_ff[DATA_W-1] ? -(DATA_W+1)'(rho_ff) : (DATA_W+1)'(rho_ff);
   assign soft_d  = $signed({1'b0, rho_mag}) - $signed({3'b000, penalty});

   always_comb begin
      if (soft_d <= 0) begin
         bn_in = '0;
      end else if (rho_ff[DATA_W-1]) begin
         bn_in = -soft_d[DATA_W-1:0];
      end else begin
         bn_in = soft_d[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start_rho) begin
         rho_neg_ff <= acc_ff[ACC_W-1];
      end
      if (cmd.rho_save) begin
         rho_ff <= sat32(rho_neg_ff ? -q_ext : q_ext);
      end
      if (cmd.bn_save) begin
         bn_ff <= bn_in;
      end
      if (cmd.coef_update) begin
         delta_ff <= (DATA_W+1)'(bn_ff) - (DATA_W+1)'(bj_ff);
      end
      if (cmd.f_save) begin
         f_ff <= OBJ_W'(div_q) + pen_ff;
      end
   end

   // Objective of the previous sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= '0;
      end else if (cmd.fold_save) begin
         fold_ff <= f_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_idx_ff    <= COL_FIELD_W'(cmd.col);
         out_val_ff    <= coef_rd;
         out_sweeps_ff <= cmd.sweeps;
         out_last_ff   <= cmd.out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coef_index  = out_idx_ff;
   assign rsp_coef_value  = out_val_ff;
   assign rsp_sweeps_done = out_sweeps_ff;
   assign rsp_last        = out_last_ff;

   // Status back to the sequencer.
   assign status.div_busy  = div_busy;
   assign status.changed   = bn_ff != bj_ff;
   assign status.converged = ($signed({1'b0, fold_ff}) - $signed({1'b0, f_ff}))
                             < $signed({{(OBJ_W+1-PEN_W){1'b0}}, tolerance});
   assign status.out_stall = rsp_valid_ff && !rsp_ready;
endmodule

[src/lcd_ctrl.sv]
// Sequencer of the lasso coordinate descent block: takes commands, walks
// rows, columns and sweeps, and drives the datapath. Depends on lcd_pkg.
module lcd_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lcd_pkg::CMD_W-1:0]        req_cmd,
   input  logic [lcd_pkg::ROW_FIELD_W-1:0]  req_row,
   input  logic [lcd_pkg::COL_FIELD_W-1:0]  req_col,
   input  logic [lcd_pkg::NROW_W-1:0]       rows_eff,
   input  logic [lcd_pkg::NCOL_W-1:0]       cols_eff,
   input  logic [lcd_pkg::SWEEP_W-1:0]      limit_eff,
   input  lcd_pkg::lcd_status_type          status,
   output lcd_pkg::lcd_cmd_type             cmd
);
   import lcd_pkg::*;

   lcd_state_type       state_ff, state_in;
   logic [ROW_W-1:0]    i_ff, i_in;
   logic [COL_W-1:0]    j_ff, j_in;
   logic [SWEEP_W-1:0]  it_ff, it_in;
   logic                init_ff, init_in;
   logic                accept, row_ok, col_ok, last_row, last_col;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign row_ok    = 32'(req_row) < MAX_ROWS;
   assign col_ok    = 32'(req_col) < MAX_COLS;
   assign last_row  = NROW_W'(i_ff) == rows_eff - NROW_W'(1);
   assign last_col  = NCOL_W'(j_ff) == cols_eff - NCOL_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         it_ff    <= '0;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         it_ff    <= it_in;
         init_ff  <= init_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      it_in    = it_ff;
      init_in  = init_ff;
      cmd        = '0;
      cmd.row    = i_ff;
      cmd.col    = j_ff;
      cmd.acc_op = ACC_HOLD;
      cmd.mul_sel = MUL_X_COEF;
      cmd.sweeps = it_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority case (req_cmd)
                  OP_LOAD_X: cmd.ld_x = row_ok && col_ok;
                  OP_LOAD_Y: cmd.ld_y = row_ok;
                  OP_LOAD_B: cmd.ld_b = col_ok;
                  OP_ZERO_B: cmd.zero_b = 1'b1;
                  OP_RUN: begin
                     cmd.loss_clr = 1'b1;
                     i_in     = '0;
                     it_in    = '0;
                     init_in  = 1'b1;
                     state_in = ST_ROW_RD;
                  end
                  default: ;
               endcase
            end
         end

         // Objective: fresh residual of each row, squared and summed.
         ST_ROW_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_ROW_LD;
         end
         ST_ROW_LD: begin
            cmd.acc_op = ACC_LOAD_Y;
            j_in       = '0;
            state_in   = ST_ELEM_RD;
         end
         ST_ELEM_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_ELEM_MUL;
         end
         ST_ELEM_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_X_COEF;
            state_in    = ST_ELEM_ACC;
         end
         ST_ELEM_ACC: begin
            cmd.acc_op = ACC_SUB;
            if (last_col) begin
               state_in = ST_ROW_RES;
            end else begin
               j_in     = j_ff + COL_W'(1);
               state_in = ST_ELEM_RD;
            end
         end
         ST_ROW_RES: begin
            cmd.res_save = 1'b1;
            state_in     = ST_ROW_SQ;
         end
         ST_ROW_SQ: begin
            cmd.mul_en       = 1'b1;
            cmd.mul_sel      = MUL_R_R;
            cmd.res_wr_fresh = init_ff;
            state_in         = ST_ROW_ACC;
         end
         ST_ROW_ACC: begin
            cmd.loss_add = 1'b1;
            if (last_row) begin
               cmd.acc_op = ACC_CLR;
               j_in       = '0;
               state_in   = ST_PEN_MUL;
            end else begin
               i_in     = i_ff + ROW_W'(1);
               state_in = ST_ROW_RD;
            end
         end

         // Objective: penalty term.
         ST_PEN_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PEN;
            state_in    = ST_PEN_ACC;
         end
         ST_PEN_ACC: begin
            cmd.acc_op = ACC_ADD;
            if (last_col) begin
               state_in = ST_OBJ_DIV;
            end else begin
               j_in     = j_ff + COL_W'(1);
               state_in = ST_PEN_MUL;
            end
         end
         ST_OBJ_DIV: begin
            cmd.pen_save       = 1'b1;
            cmd.div_start_loss = 1'b1;
            state_in           = ST_OBJ_WAIT;
         end
         ST_OBJ_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_OBJ_SUM;
            end
         end
         ST_OBJ_SUM: begin
            cmd.f_save = 1'b1;
            state_in   = ST_OBJ_CMP;
         end
         ST_OBJ_CMP: begin
            cmd.fold_save = 1'b1;
            j_in          = '0;
            if (!init_ff && (status.converged || it_ff >= limit_eff)) begin
               state_in = ST_EMIT;
            end else begin
               init_in  = 1'b0;
               it_in    = it_ff + SWEEP_W'(1);
               state_in = ST_COL_START;
            end
         end

         // Sweep: correlation of column j with the partial residual.
         ST_COL_START: begin
            cmd.acc_op  = ACC_CLR;
            cmd.bj_load = 1'b1;
            i_in        = '0;
            state_in    = ST_CR_RD;
         end
         ST_CR_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_CR_MUL1;
         end
         ST_CR_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_X_BJ;
            state_in    = ST_CR_T;
         end
         ST_CR_T: begin
            cmd.t_save = 1'b1;
            state_in   = ST_CR_MUL2;
         end
         ST_CR_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_X_T;
            state_in    = ST_CR_ACC;
         end
         ST_CR_ACC: begin
            cmd.acc_op = ACC_ADD;
            if (last_row) begin
               state_in = ST_RHO_DIV;
            end else begin
               i_in     = i_ff + ROW_W'(1);
               state_in = ST_CR_RD;
            end
         end
         ST_RHO_DIV: begin
            cmd.div_start_rho = 1'b1;
            state_in          = ST_RHO_WAIT;
         end
         ST_RHO_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_RHO_SAT;
            end
         end
         ST_RHO_SAT: begin
            cmd.rho_save = 1'b1;
            state_in     = ST_SOFT;
         end
         ST_SOFT: begin
            cmd.bn_save = 1'b1;
            state_in    = ST_UPD_CHK;
         end
         ST_UPD_CHK: begin
            if (status.changed) begin
               cmd.coef_update = 1'b1;
               i_in            = '0;
               state_in        = ST_UR_RD;
            end else if (last_col) begin
               cmd.loss_clr = 1'b1;
               i_in         = '0;
               state_in     = ST_ROW_RD;
            end else begin
               j_in     = j_ff + COL_W'(1);
               state_in = ST_COL_START;
            end
         end

         // Sweep: residual update after a coefficient change.
         ST_UR_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_UR_MUL;
         end
         ST_UR_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_X_DELTA;
            state_in    = ST_UR_WR;
         end
         ST_UR_WR: begin
            cmd.res_wr_upd = 1'b1;
            if (!last_row) begin
               i_in     = i_ff + ROW_W'(1);
               state_in = ST_UR_RD;
            end else if (last_col) begin
               cmd.loss_clr = 1'b1;
               i_in         = '0;
               state_in     = ST_ROW_RD;
            end else begin
               j_in     = j_ff + COL_W'(1);
               state_in = ST_COL_START;
            end
         end

         // Report one coefficient per transfer.
         ST_EMIT: begin
            if (!status.out_stall) begin
               cmd.out_load = 1'b1;
               cmd.out_last = last_col;
               if (last_col) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in = j_ff + COL_W'(1);
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[src/lasso_coordinate_descent.sv]
// Top level of the lasso coordinate descent block: configuration registers,
// sequencer and datapath. Depends on lcd_pkg, lcd_req_if, lcd_rsp_if,
// lcd_ctrl and lcd_datapath.
//
// Usage:
//   req_chan carries commands: load a matrix entry, a response entry or a
//   start coefficient, zero all coefficients, or run. Loads and zeroes
//   stream at one transfer per cycle.
//   A run performs full coordinate-descent sweeps and then sends one result
//   per coefficient on rsp_chan, index 0 first, last set on the final one.
//   Each sweep is followed by an objective pass, and each changed
//   coefficient adds a residual update over all rows; the single multiplier
//   and the one-bit-per-cycle divider set the run time.
//   While a run is in progress or results are being sent, req_chan.ready is
//   low. Results leave through an output register; if rsp_chan stalls, the
//   block holds the current result and waits.
//   csr_we writes register csr_index; write only while the block is idle.
//   Reset returns the registers to their defaults, zeroes the coefficients
//   and empties the result register; the stored matrix, response and
//   residual are undefined until written.
module lasso_coordinate_descent (
   input  logic                               clock,
   input  logic                               reset,
   lcd_req_if.sink                            req_chan,
   lcd_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [lcd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lcd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lcd_pkg::*;

   logic [N_REG_W-1:0] rows_ff;
   logic [P_REG_W-1:0] cols_ff;
   logic [PEN_W-1:0]   pen_ff;
   logic [PEN_W-1:0]   tol_ff;
   logic [SWEEP_W-1:0] limit_ff;
   logic [NROW_W-1:0]  rows_eff;
   logic [NCOL_W-1:0]  cols_eff;
   logic [SWEEP_W-1:0] limit_eff;
   lcd_cmd_type        cmd;
   lcd_status_type     status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= N_REG_W'(MAX_ROWS);
         cols_ff  <= P_REG_W'(MAX_COLS);
         pen_ff   <= '0;
         tol_ff   <= PEN_W'(TOL_RESET);
         limit_ff <= SWEEP_W'(LIMIT_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS:  rows_ff  <= csr_wdata[N_REG_W-1:0];
            CSR_COLS:  cols_ff  <= csr_wdata[P_REG_W-1:0];
            CSR_PEN:   pen_ff   <= csr_wdata[PEN_W-1:0];
            CSR_TOL:   tol_ff   <= csr_wdata[PEN_W-1:0];
            CSR_LIMIT: limit_ff <= csr_wdata[SWEEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp sizes and the sweep limit to their legal ranges.
   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = NROW_W'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         rows_eff = NROW_W'(MAX_ROWS);
      end else begin
         rows_eff = NROW_W'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_eff = NCOL_W'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         cols_eff = NCOL_W'(MAX_COLS);
      end else begin
         cols_eff = NCOL_W'(cols_ff);
      end
      limit_eff = (limit_ff == '0) ? SWEEP_W'(1) : limit_ff;
   end

   lcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_cmd   (req_chan.cmd),
      .req_row   (req_chan.row),
      .req_col   (req_chan.col),
      .rows_eff  (rows_eff),
      .cols_eff  (cols_eff),
      .limit_eff (limit_eff),
      .status    (status),
      .cmd       (cmd)
   );

   lcd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_row         (req_chan.row),
      .req_col         (req_chan.col),
      .req_value       (req_chan.value),
      .penalty         (pen_ff),
      .tolerance       (tol_ff),
      .rows_eff        (rows_eff),
      .status          (status),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_coef_index  (rsp_chan.coef_index),
      .rsp_coef_value  (rsp_chan.coef_value),
      .rsp_sweeps_done (rsp_chan.sweeps_done),
      .rsp_last        (rsp_chan.last)
   );
endmodule

[sim/lasso_coordinate_descent_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the lasso coordinate descent block: loads data,
// runs fits and compares every coefficient with its own fixed-point fit.
// Depends on lcd_pkg, lcd_req_if, lcd_rsp_if and lasso_coordinate_descent.

import lcd_pkg::*;

typedef struct {
   logic [COL_FIELD_W-1:0]   index;
   logic signed [DATA_W-1:0] value;
   logic [SWEEP_W-1:0]       sweeps;
   logic                     last;
} coef_result_t;

// Fixed-point lasso fit of the block, with the coefficients it must report.
class coef_checker;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

   logic signed [DATA_W-1:0] x_mem [MAX_ROWS*MAX_COLS];
   logic signed [DATA_W-1:0] y_mem [MAX_ROWS];
   logic signed [DATA_W-1:0] coefs [MAX_COLS];
   logic signed [DATA_W-1:0] resid [MAX_ROWS];
   longint                   last_objective;
   int unsigned              rows_reg, cols_reg, pen, tol, lim;
   coef_result_t             pending[$];
   int                       errors;

   function new();
      foreach (x_mem[k]) x_mem[k] = '0;
      foreach (y_mem[k]) y_mem[k] = '0;
      foreach (coefs[k]) coefs[k] = '0;
      foreach (resid[k]) resid[k] = '0;
      last_objective = 0;
      rows_reg = MAX_ROWS;
      cols_reg = MAX_COLS;
      pen = 0;
      tol = TOL_RESET;
      lim = LIMIT_RESET;
      errors = 0;
   endfunction

   function void write_reg(lcd_csr_type idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_ROWS:  rows_reg = d[N_REG_W-1:0];
         CSR_COLS:  cols_reg = d[P_REG_W-1:0];
         CSR_PEN:   pen = d;
         CSR_TOL:   tol = d;
         CSR_LIMIT: lim = d[SWEEP_W-1:0];
         default: ;
      endcase
   endfunction

   function int unsigned rows_used();
      if (rows_reg < 1) return 1;
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
   endfunction

   function int unsigned cols_used();
      if (cols_reg < 1) return 1;
      return (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
   endfunction

   function longint clip32(logic signed [127:0] v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return longint'(v);
   endfunction

   // Truncating division of an exact sum by 2^FRAC_BITS * div, saturated to 64 bits.
   function longint scale_sum(logic signed [127:0] a, int unsigned div);
      logic [127:0] m;
      m = a[127] ? -a : a;
      m = m >> FRAC_BITS;
      m = m / div;
      if (a[127]) begin
         if (m > (128'd1 << 63)) return S64_MIN;
         return longint'(-m[63:0]);
      end
      if (m > 128'(S64_MAX)) return S64_MAX;
      return longint'(m[63:0]);
   endfunction

   // Product scaled back to Q16.16, truncated toward zero.
   function longint mul_q(longint x, longint v);
      logic signed [127:0] prod;
      logic [127:0]        m;
      prod = x;
      prod = prod * v;
      m = prod[127] ? -prod : prod;
      m = m >> FRAC_BITS;
      return prod[127] ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function longint residual_of(int unsigned i, int unsigned p);
      logic signed [127:0] acc;
      acc = y_mem[i];
      acc = acc <<< FRAC_BITS;
      for (int unsigned j = 0; j < p; j++) acc -= x_mem[i*MAX_COLS+j] * coefs[j];
      return clip32(scale_sum(acc, 1));
   endfunction

   function longint objective_of(int unsigned n, int unsigned p);
      logic signed [127:0] loss, l1;
      longint              r, b;
      loss = 0;
      l1 = 0;
      for (int unsigned i = 0; i < n; i++) begin
         r = residual_of(i, p);
         loss += r * r;
      end
      for (int unsigned j = 0; j < p; j++) begin
         b = coefs[j];
         l1 += longint'(pen) * ((b < 0) ? -b : b);
      end
      return scale_sum(loss, 2 * n) + scale_sum(l1, 1);
   endfunction

   function longint shrink(longint rho);
      longint mag, d;
      mag = (rho < 0) ? -rho : rho;
      d = mag - longint'(pen);
      if (d <= 0) return 0;
      return clip32((rho > 0) ? d : -d);
   endfunction

   // A fit: sweeps of coordinate descent until the objective stops improving or the sweep limit is reached.
   function void fit_lasso();
      int unsigned         n, p, limit, sweeps;
      longint              f_old, f_new, bj, x, t, rho, bn, delta;
      logic signed [127:0] acc;
      coef_result_t        res;
      n = rows_used();
      p = cols_used();
      limit = (lim < 1) ? 1 : lim;
      for (int unsigned i = 0; i < n; i++) resid[i] = residual_of(i, p);
      f_old = objective_of(n, p);
      sweeps = 0;
      forever begin
         sweeps++;
         for (int unsigned j = 0; j < p; j++) begin
            acc = 0;
            bj = coefs[j];
            for (int unsigned i = 0; i < n; i++) begin
               x = x_mem[i*MAX_COLS+j];
               t = clip32(longint'(resid[i]) + mul_q(x, bj));
               acc += x * t;
            end
            rho = clip32(scale_sum(acc, n));
            bn = shrink(rho);
            if (bn != bj) begin
               delta = bn - bj;
               for (int unsigned i = 0; i < n; i++) begin
                  x = x_mem[i*MAX_COLS+j];
                  resid[i] = clip32(longint'(resid[i]) - mul_q(x, delta));
               end
               coefs[j] = bn;
            end
         end
         f_new = objective_of(n, p);
         if (f_old - f_new < longint'(tol) || sweeps >= limit) break;
         f_old = f_new;
      end
      last_objective = f_new;
      for (int unsigned j = 0; j < p; j++) begin
         res.index = j;
         res.value = coefs[j];
         res.sweeps = sweeps;
         res.last = (j == p - 1);
         pending.push_back(res);
      end
   endfunction

   // Applies one accepted command to the stored data.
   function void note_command(logic [CMD_W-1:0] cmd, int row, int col,
                              logic signed [DATA_W-1:0] v);
      case (cmd)
         OP_LOAD_X: x_mem[row*MAX_COLS+col] = v;
         OP_LOAD_Y: y_mem[row] = v;
         OP_LOAD_B: coefs[col] = v;
         OP_ZERO_B: foreach (coefs[k]) coefs[k] = '0;
         OP_RUN:    fit_lasso();
         default: ;
      endcase
   endfunction

   function void check_coef(coef_result_t got);
      coef_result_t want;
      if (pending.size() == 0) begin
         $error("coefficient %0d arrived with none expected", got.index);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.index !== want.index) begin
         $error("coef_index: expected %0d, actual %0d", want.index, got.index);
         errors++;
      end
      if (got.value !== want.value) begin
         $error("coef_value: expected %0d, actual %0d", want.value, got.value);
         errors++;
      end
      if (got.sweeps !== want.sweeps) begin
         $error("sweeps_done: expected %0d, actual %0d", want.sweeps, got.sweeps);
         errors++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, actual %0d", want.last, got.last);
         errors++;
      end
   endfunction
endclass

module lasso_coordinate_descent_test;
   localparam logic [CMD_W-1:0] CMD_TOP = '1;
   localparam int RAND_ITEMS   = 190;
   localparam int HOLD_CYCLES  = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lcd_req_if req_chan ();
   lcd_rsp_if rsp_chan ();

   coef_checker chk;
   bit          x_loaded [MAX_ROWS][MAX_COLS];
   bit          y_loaded [MAX_ROWS];
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          counting;
   int          rand_items;
   bit          hold_start;
   bit          hold_done = 1'b0;
   int          hold_left = 0;
   coef_result_t got;

   lasso_coordinate_descent i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: check each transfer, then pick the next ready level.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.index = rsp_chan.coef_index;
            got.value = rsp_chan.coef_value;
            got.sweeps = rsp_chan.sweeps_done;
            got.last = rsp_chan.last;
            chk.check_coef(got);
         end
         // The long stall begins once a result waits in the block.
         if (hold_start && !hold_done && rsp_chan.valid) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic signed [DATA_W-1:0] small_value();
      return $urandom_range(262144) - 131072;
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_value();
      case ($urandom_range(9))
         6, 7:    return $urandom;
         8:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         9:       return $urandom_range(8388608) - 4194304;
         default: return small_value();
      endcase
   endfunction

   // One command transfer, after an optional random gap.
   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int row, input int col,
                           input logic signed [DATA_W-1:0] v);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(6, 1) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd <= cmd;
      req_chan.row <= row;
      req_chan.col <= col;
      req_chan.value <= v;
      do @(posedge clock); while (!req_chan.ready);
      chk.note_command(cmd, row, col, v);
      if (cmd == OP_LOAD_X) x_loaded[row][col] = 1'b1;
      if (cmd == OP_LOAD_Y) y_loaded[row] = 1'b1;
      if (counting && cmd <= OP_RUN) rand_items++;
   endtask

   // Wait until every expected coefficient is in and the block is quiet.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (chk.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int unsigned rows, input int unsigned cols,
                            input int unsigned penalty, input int unsigned tolerance,
                            input int unsigned limit);
      lcd_csr_type          idx [5];
      logic [CSR_DATA_W-1:0] val [5];
      idx = '{CSR_ROWS, CSR_COLS, CSR_PEN, CSR_TOL, CSR_LIMIT};
      val = '{rows, cols, penalty, tolerance, limit};
      settle();
      for (int k = 0; k < 5; k++) begin
         csr_we <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         chk.write_reg(idx[k], val[k]);
      end
      csr_we <= 1'b0;
   endtask

   // Fill every entry the next fit reads and has not been written, then run.
   task automatic run_fit();
      for (int i = 0; i < chk.rows_used(); i++) begin
         if (!y_loaded[i]) send_cmd(OP_LOAD_Y, i, $urandom_range(31), small_value());
         for (int j = 0; j < chk.cols_used(); j++)
            if (!x_loaded[i][j]) send_cmd(OP_LOAD_X, i, j, small_value());
      end
      send_cmd(OP_RUN, $urandom_range(255), $urandom_range(31), $urandom);
   endtask

   task automatic random_command();
      int row, col;
      row = $urandom_range(1) ? $urandom_range(255) : $urandom_range(7);
      col = $urandom_range(1) ? $urandom_range(31) : $urandom_range(3);
      case ($urandom_range(9))
         0:       send_cmd($urandom_range(CMD_TOP, OP_RUN + 1), row, col, $urandom);
         1:       send_cmd(OP_ZERO_B, row, col, $urandom);
         2, 3:    send_cmd(OP_LOAD_Y, row, col, rand_value());
         4:       send_cmd(OP_LOAD_B, row, col, rand_value());
         default: send_cmd(OP_LOAD_X, row, col, rand_value());
      endcase
   endtask

   initial begin
      chk = new();
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_ROWS;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.cmd <= OP_ZERO_B;
      req_chan.row <= '0;
      req_chan.col <= '0;
      req_chan.value <= '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      counting = 1'b0;
      rand_items = 0;
      hold_start = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme values and indexes, every command, unused codes.
      configure(4, 3, 0, TOL_RESET, 50);
      send_cmd(OP_LOAD_X, 0, 0, 32'sh7FFF_FFFF);
      send_cmd(OP_LOAD_X, 1, 0, 32'sh8000_0000);
      send_cmd(OP_LOAD_X, 255, 31, -1);
      send_cmd(OP_LOAD_Y, 0, 0, 32'sh7FFF_FFFF);
      send_cmd(OP_LOAD_Y, 255, 0, 32'sh8000_0000);
      send_cmd(OP_LOAD_B, 0, 31, 32'sh7FFF_FFFF);
      send_cmd(OP_LOAD_B, 0, 0, 32'sh0001_0000);
      for (int c = OP_RUN + 1; c <= CMD_TOP; c++) send_cmd(c, 255, 31, $urandom);
      send_cmd(OP_ZERO_B, 0, 0, 0);
      send_cmd(OP_LOAD_B, 0, 1, -32'sh0001_0000);
      run_fit();

      // Warm start with a penalty, then a penalty that zeroes everything.
      configure(4, 3, 32'h8000, 0, 20);
      run_fit();
      configure(4, 3, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 65535);
      run_fit();

      // Zero sizes and a zero limit act as one.
      configure(0, 0, 0, 0, 0);
      run_fit();

      // An oversized column count clamps to the full width; one sweep ends the run.
      configure(1, 63, 32'h4000, 31'h7FFF_FFFF, 65535);
      send_cmd(OP_ZERO_B, 0, 0, 0);
      run_fit();

      // Random: short load sequences, each ending in a fit on small data.
      counting = 1'b1;
      while (rand_items < RAND_ITEMS) begin
         if (rand_items < RAND_ITEMS / 3) begin
            send_idle_pct = 26;
            recv_idle_pct = 66;
         end else if (rand_items < 2 * RAND_ITEMS / 3) begin
            send_idle_pct = 66;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(3))
            0:       configure($urandom_range(8, 1), $urandom_range(4, 1), 0, 0,
                               $urandom_range(20, 1));
            1:       configure($urandom_range(8, 1), $urandom_range(4, 1),
                               $urandom_range(65536), TOL_RESET, $urandom_range(20, 1));
            2:       configure($urandom_range(8, 1), $urandom_range(4, 1),
                               $urandom_range(1 << 20), $urandom_range(1 << 16),
                               $urandom_range(20, 1));
            default: configure($urandom_range(8, 1), $urandom_range(4, 1),
                               $urandom & 31'h7FFF_FFFF, $urandom & 31'h7FFF_FFFF,
                               $urandom_range(20, 1));
         endcase
         repeat ($urandom_range(12)) random_command();
         if (!hold_start) begin
            // Stall the results for a long stretch while loads keep coming.
            hold_start <= 1'b1;
            run_fit();
            repeat (4) send_cmd(OP_LOAD_Y, $urandom_range(7), 0, small_value());
         end else begin
            run_fit();
         end
      end

      settle();
      if (chk.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #50_000_000;
      $display("FAIL");
      $finish;
   end
endmodule
